FILE: rtl/pcv_pkg.sv
// shared types, constants and register codes of the point cloud voxelizer
`timescale 1ns / 1ps
package pcv_pkg;

  localparam int COORD_W = 24;
  localparam int SIZE_W  = 16;
  localparam int VLIM_W  = 15;
  localparam int PLIM_W  = 6;
  localparam int INT_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int EPOCH_W = 4;

  localparam int GRID_X_DEF     = 512;
  localparam int GRID_Y_DEF     = 512;
  localparam int GRID_Z_DEF     = 2;
  localparam int VOXEL_CAP_DEF  = 16384;
  localparam int MAX_POINTS_DEF = 32;

  localparam logic signed [COORD_W-1:0] RANGE_LOW_X_RST = -24'sd8192;
  localparam logic signed [COORD_W-1:0] RANGE_LOW_Y_RST = -24'sd40960;
  localparam logic signed [COORD_W-1:0] RANGE_LOW_Z_RST = -24'sd3072;
  localparam logic [SIZE_W-1:0] CELL_SIZE_X_RST = 16'd164;
  localparam logic [SIZE_W-1:0] CELL_SIZE_Y_RST = 16'd164;
  localparam logic [SIZE_W-1:0] CELL_SIZE_Z_RST = 16'd4096;
  localparam logic [VLIM_W-1:0] VOXEL_LIMIT_RST = 15'd12000;
  localparam logic [PLIM_W-1:0] POINTS_LIMIT_RST = 6'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_LOW_X  = 3'd0,
    REG_RANGE_LOW_Y  = 3'd1,
    REG_RANGE_LOW_Z  = 3'd2,
    REG_CELL_SIZE_X  = 3'd3,
    REG_CELL_SIZE_Y  = 3'd4,
    REG_CELL_SIZE_Z  = 3'd5,
    REG_VOXEL_LIMIT  = 3'd6,
    REG_POINTS_LIMIT = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_STORED     = 2'd0,
    ST_OUT_RANGE  = 2'd1,
    ST_VOXEL_FULL = 2'd2,
    ST_TABLE_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic                      frame_start;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic [INT_W-1:0]          point_intensity;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [13:0]               voxel_index;
    logic [4:0]                slot;
    logic                      new_voxel;
    logic [8:0]                cell_x;
    logic [8:0]                cell_y;
    logic                      cell_z;
    logic [14:0]               voxel_total;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic [INT_W-1:0]          out_intensity;
  } out_item_t;

endpackage

FILE: rtl/pcv_if.sv
// request channel interfaces for points in and write commands out
`timescale 1ns / 1ps
interface pcv_in_if;
  logic               valid;
  logic               ready;
  pcv_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pcv_out_if;
  logic               valid;
  logic               ready;
  pcv_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/point_cloud_voxelizer.sv
// top level of the point cloud voxelizer
`timescale 1ns / 1ps
// one point is taken at a time: it is accepted only while the sequencer is idle and the
// result leaves through an output register, so the next point may enter while the last
// result still waits. a point passes through accept and set-up, then one division for each
// axis that is divided (the shared restoring divider gives one quotient bit per cycle),
// then the cell map and fill count lookups; a point that falls outside the grid early or
// arrives after the table has stopped skips the later steps. the cell map tags each entry
// with a frame epoch, so a frame start costs nothing, except that after reset and on every
// fifteenth frame start a clearing pass sweeps all GRID_X * GRID_Y * GRID_Z entries of the
// map, one entry a cycle, while no point is taken.
module point_cloud_voxelizer #(
  parameter int GRID_X     = pcv_pkg::GRID_X_DEF,
  parameter int GRID_Y     = pcv_pkg::GRID_Y_DEF,
  parameter int GRID_Z     = pcv_pkg::GRID_Z_DEF,
  parameter int VOXEL_CAP  = pcv_pkg::VOXEL_CAP_DEF,
  parameter int MAX_POINTS = pcv_pkg::MAX_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  pcv_in_if.sink                        in_req,
  pcv_out_if.source                     out_res,
  input  logic                          cfg_we,
  input  logic [pcv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcv_pkg::CFG_DATA_W-1:0] cfg_data
);
  localparam int CW_ = pcv_pkg::COORD_W;
  localparam int SW_ = pcv_pkg::SIZE_W;
  localparam int EW_ = pcv_pkg::EPOCH_W;
  localparam int MAP_DEPTH = GRID_X * GRID_Y * GRID_Z;
  localparam int KEY_W = MAP_DEPTH > 1 ? $clog2(MAP_DEPTH) : 1;
  localparam int CX_W  = GRID_X > 1 ? $clog2(GRID_X) : 1;
  localparam int CY_W  = GRID_Y > 1 ? $clog2(GRID_Y) : 1;
  localparam int CZ_W  = GRID_Z > 1 ? $clog2(GRID_Z) : 1;
  localparam int VOX_W = VOXEL_CAP > 1 ? $clog2(VOXEL_CAP) : 1;
  localparam int CNT_W = $clog2(VOXEL_CAP + 1);
  localparam int PT_W  = $clog2(MAX_POINTS + 1);
  localparam int ENT_W = EW_ + VOX_W;
  localparam int LIM_W = CNT_W > pcv_pkg::VLIM_W ? CNT_W : pcv_pkg::VLIM_W;
  localparam int LP_W  = PT_W > pcv_pkg::PLIM_W ? PT_W : pcv_pkg::PLIM_W;
  localparam logic [CW_-1:0] GX_L = CW_'(GRID_X);
  localparam logic [CW_-1:0] GY_L = CW_'(GRID_Y);
  localparam logic [CW_-1:0] GZ_L = CW_'(GRID_Z);
  localparam logic [EW_-1:0] EPOCH_LAST = '1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_CLEAR  = 11'b000_0000_0010,
    S_START  = 11'b000_0000_0100,
    S_AXIS   = 11'b000_0000_1000,
    S_DIV    = 11'b000_0001_0000,
    S_KEY    = 11'b000_0010_0000,
    S_MAPRD  = 11'b000_0100_0000,
    S_LOOK   = 11'b000_1000_0000,
    S_FILLRD = 11'b001_0000_0000,
    S_UPD    = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } state_t;

  // configuration registers
  logic signed [CW_-1:0]          low_x_r, low_y_r, low_z_r;
  logic [SW_-1:0]                 size_x_r, size_y_r, size_z_r;
  logic [pcv_pkg::VLIM_W-1:0]     vlim_r;
  logic [pcv_pkg::PLIM_W-1:0]     plim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_x_r  <= pcv_pkg::RANGE_LOW_X_RST;
      low_y_r  <= pcv_pkg::RANGE_LOW_Y_RST;
      low_z_r  <= pcv_pkg::RANGE_LOW_Z_RST;
      size_x_r <= pcv_pkg::CELL_SIZE_X_RST;
      size_y_r <= pcv_pkg::CELL_SIZE_Y_RST;
      size_z_r <= pcv_pkg::CELL_SIZE_Z_RST;
      vlim_r   <= pcv_pkg::VOXEL_LIMIT_RST;
      plim_r   <= pcv_pkg::POINTS_LIMIT_RST;
    end else if (cfg_we) begin
      case (pcv_pkg::cfg_reg_t'(cfg_index))
        pcv_pkg::REG_RANGE_LOW_X:  low_x_r  <= cfg_data;
        pcv_pkg::REG_RANGE_LOW_Y:  low_y_r  <= cfg_data;
        pcv_pkg::REG_RANGE_LOW_Z:  low_z_r  <= cfg_data;
        pcv_pkg::REG_CELL_SIZE_X:  size_x_r <= cfg_data[SW_-1:0];
        pcv_pkg::REG_CELL_SIZE_Y:  size_y_r <= cfg_data[SW_-1:0];
        pcv_pkg::REG_CELL_SIZE_Z:  size_z_r <= cfg_data[SW_-1:0];
        pcv_pkg::REG_VOXEL_LIMIT:  vlim_r   <= cfg_data[pcv_pkg::VLIM_W-1:0];
        pcv_pkg::REG_POINTS_LIMIT: plim_r   <= cfg_data[pcv_pkg::PLIM_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and frame state
  state_t             state_r;
  logic               pend_r;       // item waits behind a clearing pass
  logic [KEY_W-1:0]   clr_r;
  logic [EW_-1:0]     epoch_r;
  logic [CNT_W-1:0]   count_r;
  logic               stop_r;
  logic [1:0]         axis_r;
  logic               lim_hit;

  // current point and result under construction
  pcv_pkg::in_item_t  item_r;
  logic [1:0]         status_r;
  logic [CX_W-1:0]    cx_r;
  logic [CY_W-1:0]    cy_r;
  logic [CZ_W-1:0]    cz_r;
  logic [KEY_W-1:0]   key_r;
  logic [VOX_W-1:0]   v_r;
  logic               fresh_r;
  logic [PT_W-1:0]    slot_r;

  logic               out_valid_r;
  pcv_pkg::out_item_t out_data_r;

  // axis selection for the shared divider
  logic signed [CW_-1:0] sel_p, sel_low;
  logic [SW_-1:0]        sel_size;
  logic [CW_-1:0]        sel_grid;
  logic [CW_:0]          diff;
  logic                  axis_bad;

  always_comb begin
    case (axis_r)
      AXIS_X: begin
        sel_p = item_r.point_x; sel_low = low_x_r; sel_size = size_x_r; sel_grid = GX_L;
      end
      AXIS_Y: begin
        sel_p = item_r.point_y; sel_low = low_y_r; sel_size = size_y_r; sel_grid = GY_L;
      end
      default: begin
        sel_p = item_r.point_z; sel_low = low_z_r; sel_size = size_z_r; sel_grid = GZ_L;
      end
    endcase
    diff     = {sel_p[CW_-1], sel_p} - {sel_low[CW_-1], sel_low};
    axis_bad = diff[CW_] || (sel_size == '0);
  end

  logic          div_start, div_done;
  logic [CW_-1:0] quo;

  assign div_start = (state_r == S_AXIS) && !axis_bad;

  pcv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (diff[CW_-1:0]),
    .divisor  (sel_size),
    .done     (div_done),
    .quotient (quo)
  );

  // cell map: epoch tag and voxel index per grid cell
  logic             map_we;
  logic [KEY_W-1:0] map_waddr;
  logic [ENT_W-1:0] map_wdata, map_rdata;
  logic [EW_-1:0]   map_epoch;
  logic [VOX_W-1:0] map_vox;

  always_comb begin
    map_we    = 1'b0;
    map_waddr = key_r;
    map_wdata = {epoch_r, count_r[VOX_W-1:0]};
    if (state_r == S_CLEAR) begin
      map_we    = 1'b1;
      map_waddr = clr_r;
      map_wdata = '0;
    end else if (state_r == S_LOOK && !(map_epoch == epoch_r) && !lim_hit) begin
      map_we = 1'b1;
    end
  end

  assign {map_epoch, map_vox} = map_rdata;

  pcv_ram #(.WIDTH(ENT_W), .DEPTH(MAP_DEPTH)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (key_r),
    .rdata (map_rdata)
  );

  // fill counts, written at allocation and on every stored point
  logic             fill_we;
  logic [PT_W-1:0]  fill_wdata, fill_rdata, n_cur;
  logic             n_ok;

  always_comb begin
    lim_hit = (LIM_W'(count_r) >= LIM_W'(vlim_r)) ||
              (LIM_W'(count_r) >= LIM_W'(VOXEL_CAP));
    n_cur   = fresh_r ? '0 : fill_rdata;
    n_ok    = (LP_W'(n_cur) < LP_W'(plim_r)) && (LP_W'(n_cur) < LP_W'(MAX_POINTS));
    fill_we = (state_r == S_UPD);
    fill_wdata = n_ok ? PT_W'(n_cur + 1'b1) : n_cur;
  end

  pcv_ram #(.WIDTH(PT_W), .DEPTH(VOXEL_CAP)) u_fill (
    .clk   (clk),
    .we    (fill_we),
    .waddr (v_r),
    .wdata (fill_wdata),
    .raddr (v_r),
    .rdata (fill_rdata)
  );

  logic in_take, out_load;
  assign in_take  = in_req.valid && (state_r == S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_res.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      pend_r      <= 1'b0;
      clr_r       <= '0;
      epoch_r     <= EW_'(1);
      count_r     <= '0;
      stop_r      <= 1'b0;
      axis_r      <= AXIS_X;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_res.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_take) begin
            if (in_req.data.frame_start) begin
              count_r <= '0;
              stop_r  <= 1'b0;
              if (epoch_r == EPOCH_LAST) begin
                // tags would come round again: sweep the map first
                epoch_r <= EW_'(1);
                pend_r  <= 1'b1;
                clr_r   <= '0;
                state_r <= S_CLEAR;
              end else begin
                epoch_r <= epoch_r + 1'b1;
                state_r <= S_START;
              end
            end else begin
              state_r <= S_START;
            end
          end
        end
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == KEY_W'(MAP_DEPTH - 1)) begin
            pend_r  <= 1'b0;
            state_r <= pend_r ? S_START : S_IDLE;
          end
        end
        S_START: begin
          axis_r <= AXIS_X;
          state_r <= stop_r ? S_DONE : S_AXIS;
        end
        S_AXIS: begin
          state_r <= axis_bad ? S_DONE : S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (quo >= sel_grid) begin
              state_r <= S_DONE;
            end else if (axis_r == AXIS_Z) begin
              state_r <= S_KEY;
            end else begin
              axis_r  <= axis_r + 1'b1;
              state_r <= S_AXIS;
            end
          end
        end
        S_KEY:    state_r <= S_MAPRD;
        S_MAPRD:  state_r <= S_LOOK;
        S_LOOK: begin
          if (map_epoch == epoch_r) begin
            state_r <= S_FILLRD;
          end else if (lim_hit) begin
            // table full: the rest of the frame is dropped
            stop_r  <= 1'b1;
            state_r <= S_DONE;
          end else begin
            count_r <= count_r + 1'b1;
            state_r <= S_FILLRD;
          end
        end
        S_FILLRD: state_r <= S_UPD;
        S_UPD:    state_r <= S_DONE;
        S_DONE: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result fields, built up as the sequencer goes
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= in_req.data;
    end
    case (state_r)
      S_START: begin
        status_r <= pcv_pkg::ST_TABLE_FULL;
        cx_r     <= '0;
        cy_r     <= '0;
        cz_r     <= '0;
        v_r      <= '0;
        slot_r   <= '0;
        fresh_r  <= 1'b0;
      end
      S_AXIS: begin
        if (axis_bad) begin
          status_r <= pcv_pkg::ST_OUT_RANGE;
          cx_r <= '0;
          cy_r <= '0;
          cz_r <= '0;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (quo >= sel_grid) begin
            status_r <= pcv_pkg::ST_OUT_RANGE;
            cx_r <= '0;
            cy_r <= '0;
            cz_r <= '0;
          end else begin
            case (axis_r)
              AXIS_X:  cx_r <= quo[CX_W-1:0];
              AXIS_Y:  cy_r <= quo[CY_W-1:0];
              default: cz_r <= quo[CZ_W-1:0];
            endcase
          end
        end
      end
      S_KEY: begin
        key_r <= KEY_W'(cz_r) + KEY_W'(cy_r) * KEY_W'(GRID_Z)
               + KEY_W'(cx_r) * KEY_W'(GRID_Y * GRID_Z);
      end
      S_LOOK: begin
        if (map_epoch == epoch_r) begin
          v_r <= map_vox;
        end else if (!lim_hit) begin
          v_r     <= count_r[VOX_W-1:0];
          fresh_r <= 1'b1;
        end
      end
      S_UPD: begin
        if (n_ok) begin
          status_r <= pcv_pkg::ST_STORED;
          slot_r   <= n_cur;
        end else begin
          status_r <= pcv_pkg::ST_VOXEL_FULL;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_data_r.status        <= status_r;
      out_data_r.voxel_index   <= 14'(v_r);
      out_data_r.slot          <= 5'(slot_r);
      out_data_r.new_voxel     <= fresh_r;
      out_data_r.cell_x        <= 9'(cx_r);
      out_data_r.cell_y        <= 9'(cy_r);
      out_data_r.cell_z        <= cz_r[0];
      out_data_r.voxel_total   <= 15'(count_r);
      out_data_r.out_x         <= item_r.point_x;
      out_data_r.out_y         <= item_r.point_y;
      out_data_r.out_z         <= item_r.point_z;
      out_data_r.out_intensity <= item_r.point_intensity;
    end
  end

  assign in_req.ready  = (state_r == S_IDLE);
  assign out_res.valid = out_valid_r;
  assign out_res.data  = out_data_r;
endmodule

FILE: rtl/pcv_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module pcv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

FILE: rtl/pcv_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module pcv_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pcv_pkg::COORD_W-1:0] dividend,
  input  logic [pcv_pkg::SIZE_W-1:0]  divisor,
  output logic                        done,
  output logic [pcv_pkg::COORD_W-1:0] quotient
);
  localparam int QW = pcv_pkg::COORD_W;
  localparam int DW = pcv_pkg::SIZE_W;
  localparam int CW = $clog2(QW);

  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [QW-1:0] quo_r;
  logic [DW-1:0] rem_r, div_r;
  logic [DW:0]   shifted;
  logic          ge;
  logic [DW-1:0] rem_nxt;

  always_comb begin
    shifted = {rem_r, quo_r[QW-1]};
    ge      = shifted >= {1'b0, div_r};
    rem_nxt = ge ? DW'(shifted - {1'b0, div_r}) : shifted[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[QW-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule
